// File: rtl/core/bedm_pkg.sv
package bedm_pkg;

  // Field widths fixed by the interface
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned DIST_W = 3;
  localparam int unsigned SEEN_W = 6;
  localparam int unsigned LEN_REG_W = 5;
  localparam int unsigned EDITS_W = 3;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_IDX_W = 2;

  // Design limits
  localparam int unsigned MAX_PATTERN_DEF = 16;
  localparam logic [EDITS_W-1:0] MAX_EDITS_LIMIT = 3'd6;
  localparam logic [EDITS_W-1:0] MAX_EDITS_RESET = 3'd1;
  localparam logic [DIST_W-1:0] RESET_CAP = 3'd2;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAT_LEN   = 2'd0,
    REG_PAT_LO    = 2'd1,
    REG_PAT_HI    = 2'd2,
    REG_MAX_EDITS = 2'd3
  } cfg_reg_e;

  // Character request travelling down the cell row
  typedef struct packed {
    logic              valid;
    logic [CHAR_W-1:0] chr;
    logic              first;  // first character of a word
    logic              fin;    // word ends here (last char or empty word)
    logic              empty;  // zero-length word
    logic [DIST_W-1:0] left;   // new value of the left neighbor cell
    logic [DIST_W-1:0] diag;   // old value of the left neighbor cell
  } tok_t;

  // What a stage shows to the result tap
  typedef struct packed {
    logic              valid;
    logic              fin;
    logic              empty;
    logic [DIST_W-1:0] val;
  } stage_t;

  // Clamp a distance to the saturation cap
  function automatic logic [DIST_W-1:0] clamp_dist(logic [DIST_W:0] v, logic [DIST_W-1:0] cap);
    logic [DIST_W-1:0] r;
    r = (v > {1'b0, cap}) ? cap : v[DIST_W-1:0];
    return r;
  endfunction

endpackage

// File: rtl/core/bedm_head.sv
module bedm_head (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  logic                          in_valid_i,
  input  logic [bedm_pkg::CHAR_W-1:0]   in_chr_i,
  input  logic                          in_last_i,
  input  logic                          in_empty_i,
  input  logic [bedm_pkg::DIST_W-1:0]   cap_i,
  output bedm_pkg::tok_t                tok_o,
  output bedm_pkg::stage_t              stat_o
);
  import bedm_pkg::*;

  tok_t              in_q;
  tok_t              tok_q;
  tok_t              tok_d;
  logic [SEEN_W-1:0] seen_q;
  logic [DIST_W-1:0] r0_q;

  logic              first;
  logic [DIST_W-1:0] d0;
  logic [DIST_W-1:0] prev0;
  logic [SEEN_W-1:0] seen_inc;

  // Column zero of the new row and the old value handed on as diagonal
  always_comb begin
    first = (seen_q == '0);
    d0 = clamp_dist(DIST_W'(0) + ((seen_q >= SEEN_W'(7)) ? {1'b0, 3'd7}
                    : {1'b0, seen_q[DIST_W-1:0]} + 4'd1), cap_i);
    prev0 = first ? '0 : clamp_dist({1'b0, r0_q}, cap_i);
    seen_inc = (seen_q == {SEEN_W{1'b1}}) ? seen_q : seen_q + SEEN_W'(1);
    tok_d       = in_q;
    tok_d.first = first;
    tok_d.left  = d0;
    tok_d.diag  = prev0;
  end

  // Capture the request, advance column zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_q   <= '0;
      tok_q  <= '0;
      seen_q <= '0;
      r0_q   <= '0;
    end else if (adv_i) begin
      in_q.valid <= in_valid_i;
      in_q.chr   <= in_chr_i;
      in_q.first <= 1'b0;
      in_q.fin   <= in_last_i | in_empty_i;
      in_q.empty <= in_empty_i;
      in_q.left  <= '0;
      in_q.diag  <= '0;

      tok_q <= tok_d;

      if (in_q.valid) begin
        if (in_q.fin) begin
          seen_q <= '0;
          r0_q   <= '0;
        end else begin
          seen_q <= seen_inc;
          r0_q   <= d0;
        end
      end
    end
  end

  assign tok_o = tok_q;

  assign stat_o.valid = in_q.valid;
  assign stat_o.fin   = in_q.fin;
  assign stat_o.empty = in_q.empty;
  assign stat_o.val   = d0;

endmodule

// File: rtl/core/bedm_cell.sv
module bedm_cell #(
  parameter int unsigned IDX   = 1,
  parameter int unsigned LEN_W = 5
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  bedm_pkg::tok_t                tok_i,
  input  logic [LEN_W-1:0]              len_i,
  input  logic [bedm_pkg::DIST_W-1:0]   cap_i,
  input  logic [bedm_pkg::CHAR_W-1:0]   pchar_i,
  output bedm_pkg::tok_t                tok_o,
  output bedm_pkg::stage_t              stat_o
);
  import bedm_pkg::*;

  localparam logic [DIST_W:0] IDX_SAT = (IDX > 7) ? 4'd7 : (DIST_W+1)'(IDX);
  localparam logic [DIST_W-1:0] RESET_VAL = (IDX_SAT > {1'b0, RESET_CAP}) ? RESET_CAP
                                            : IDX_SAT[DIST_W-1:0];

  logic [DIST_W-1:0] r_q;
  tok_t              tok_q;
  tok_t              tok_d;

  logic [DIST_W-1:0] zero_val;
  logic [DIST_W-1:0] prev;
  logic [DIST_W:0]   ins;
  logic [DIST_W:0]   del;
  logic [DIST_W:0]   sub;
  logic [DIST_W:0]   m;
  logic [DIST_W-1:0] nval;
  logic              active;

  // One step of the edit-distance recurrence
  always_comb begin
    zero_val = clamp_dist(IDX_SAT, cap_i);
    prev     = tok_i.first ? zero_val : clamp_dist({1'b0, r_q}, cap_i);
    ins      = {1'b0, tok_i.left} + 4'd1;
    del      = {1'b0, prev} + 4'd1;
    sub      = {1'b0, tok_i.diag} + {{DIST_W{1'b0}}, (tok_i.chr != pchar_i)};
    m        = (ins < del) ? ins : del;
    if (sub < m) begin
      m = sub;
    end
    nval   = clamp_dist(m, cap_i);
    active = (LEN_W'(IDX) <= len_i);
    tok_d      = tok_i;
    tok_d.left = nval;
    tok_d.diag = prev;
  end

  // Store the row cell, hand the request on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_q   <= RESET_VAL;
      tok_q <= '0;
    end else if (adv_i) begin
      tok_q <= tok_d;
      if (tok_i.valid) begin
        if (tok_i.fin) begin
          r_q <= zero_val;
        end else if (active) begin
          r_q <= nval;
        end
      end
    end
  end

  assign tok_o = tok_q;

  assign stat_o.valid = tok_i.valid;
  assign stat_o.fin   = tok_i.fin;
  assign stat_o.empty = tok_i.empty;
  assign stat_o.val   = nval;

endmodule

// File: rtl/core/bedm_out_fifo.sv
module bedm_out_fifo #(
  parameter int unsigned DATA_W = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] data_i,
  input  logic              pop_i,
  output logic              full_o,
  output logic              valid_o,
  output logic [DATA_W-1:0] data_o
);

  logic [DATA_W-1:0] mem_q [2];
  logic              wr_q;
  logic              rd_q;
  logic [1:0]        cnt_q;

  // Two-entry result queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_q];

endmodule

// File: rtl/core/bounded_edit_distance_matcher_core.sv
// Bounded edit distance matcher. Candidate words stream in one character per
// request (tlast marks the final character, tuser marks a zero-length word) and
// each is compared with the configured pattern of up to MAX_PATTERN characters.
// A row of MAX_PATTERN cells behind a column-zero stage holds one row of edit
// distances; while the row is not halted a character moves one cell per cycle,
// so the block takes one character every cycle. A word's result (match flag
// and distance saturated at max_edits + 1, max_edits capped at 6) is tapped at
// the pattern's last cell. Results go through a two-entry queue; the cell row
// halts only when a result reaches the tap while that queue is full and not
// being drained. Write configuration only when no request is in the cell row
// (MAX_PATTERN + 2 cycles after the last request).
module bounded_edit_distance_matcher_core #(
  parameter int unsigned MAX_PATTERN = bedm_pkg::MAX_PATTERN_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // config write port
  input  logic                             cfg_we_i,
  input  logic [bedm_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [bedm_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // character stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [7:0]                       s_axis_tdata,   // [7:0] text_char
  input  logic                             s_axis_tlast,
  input  logic                             s_axis_tuser,   // [0] empty_word
  // result stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [7:0]                       m_axis_tdata    // [0] matched, [3:1] distance
);
  import bedm_pkg::*;

  localparam int unsigned LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int unsigned RES_W = 1 + DIST_W;

  logic [LEN_REG_W-1:0]  len_q;
  logic [CFG_DATA_W-1:0] pat_lo_q;
  logic [CFG_DATA_W-1:0] pat_hi_q;
  logic [EDITS_W-1:0]    edits_q;

  logic [EDITS_W-1:0]    edits_eff;
  logic [DIST_W-1:0]     cap;
  logic [LEN_W-1:0]      len_eff;
  logic [2*CFG_DATA_W-1:0] pat;

  tok_t   tk   [1:MAX_PATTERN+1];
  stage_t stat [0:MAX_PATTERN];

  stage_t            tap;
  logic              res_valid;
  logic [DIST_W-1:0] res_dist;
  logic [RES_W-1:0]  res_data;
  logic              fifo_full;
  logic              fifo_valid;
  logic [RES_W-1:0]  fifo_data;
  logic              pop;
  logic              adv;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q    <= '0;
      pat_lo_q <= '0;
      pat_hi_q <= '0;
      edits_q  <= MAX_EDITS_RESET;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_PAT_LEN:   len_q    <= cfg_data_i[LEN_REG_W-1:0];
        REG_PAT_LO:    pat_lo_q <= cfg_data_i;
        REG_PAT_HI:    pat_hi_q <= cfg_data_i;
        REG_MAX_EDITS: edits_q  <= cfg_data_i[EDITS_W-1:0];
        default:       len_q    <= len_q;
      endcase
    end
  end

  // Effective limits
  always_comb begin
    edits_eff = (edits_q > MAX_EDITS_LIMIT) ? MAX_EDITS_LIMIT : edits_q;
    cap       = edits_eff + DIST_W'(1);
    len_eff   = ({{(32-LEN_REG_W){1'b0}}, len_q} > MAX_PATTERN) ? LEN_W'(MAX_PATTERN)
                : LEN_W'(len_q);
    pat       = {pat_hi_q, pat_lo_q};
  end

  // Column zero and request capture
  bedm_head u_head (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .in_valid_i (s_axis_tvalid),
    .in_chr_i   (s_axis_tdata),
    .in_last_i  (s_axis_tlast),
    .in_empty_i (s_axis_tuser),
    .cap_i      (cap),
    .tok_o      (tk[1]),
    .stat_o     (stat[0])
  );

  // Row of pattern cells
  for (genvar k = 1; k <= MAX_PATTERN; k++) begin : g_cell
    bedm_cell #(
      .IDX   (k),
      .LEN_W (LEN_W)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .tok_i   (tk[k]),
      .len_i   (len_eff),
      .cap_i   (cap),
      .pchar_i (pat[CHAR_W*(k-1) +: CHAR_W]),
      .tok_o   (tk[k+1]),
      .stat_o  (stat[k])
    );
  end

  // Tap the result at the cell of the pattern's last character
  always_comb begin
    tap       = stat[len_eff];
    res_valid = tap.valid & tap.fin;
    res_dist  = tap.empty ? clamp_dist((DIST_W+1)'(len_eff > LEN_W'(7) ? LEN_W'(7) : len_eff),
                                       cap)
                          : tap.val;
    res_data  = {res_dist, (res_dist < cap)};
    pop       = fifo_valid & m_axis_tready;
    adv       = !(res_valid && fifo_full && !pop);
  end

  bedm_out_fifo #(
    .DATA_W (RES_W)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid & adv),
    .data_i  (res_data),
    .pop_i   (pop),
    .full_o  (fifo_full),
    .valid_o (fifo_valid),
    .data_o  (fifo_data)
  );

  assign s_axis_tready = adv;
  assign m_axis_tvalid = fifo_valid;
  assign m_axis_tdata  = {{(8-RES_W){1'b0}}, fifo_data};

endmodule

// File: sim/tb_bounded_edit_distance_matcher_core.sv
`timescale 1ns / 1ps

module tb_bounded_edit_distance_matcher_core;
  import bedm_pkg::*;

  localparam int ROW_CELLS   = MAX_PATTERN_DEF;
  localparam int SEEN_SAT    = 63;
  localparam int ROW_SETTLE  = ROW_CELLS + 4;
  localparam int LONG_HOLD   = 300;
  localparam int STUCK_LIMIT = 4000;

  typedef logic [CHAR_W-1:0] word_t[$];

  typedef struct packed {
    logic              matched;
    logic [DIST_W-1:0] distance;
  } verdict_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata;   // [7:0] text_char
  logic                  s_axis_tlast;
  logic                  s_axis_tuser;   // [0] empty_word
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [7:0]            m_axis_tdata;   // [0] matched, [3:1] distance

  bounded_edit_distance_matcher_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Shadow copy of the configuration and the distance row
  logic [LEN_REG_W-1:0]  pat_len;
  logic [CFG_DATA_W-1:0] pat_lo;
  logic [CFG_DATA_W-1:0] pat_hi;
  logic [EDITS_W-1:0]    pat_edits;
  logic [DIST_W-1:0]     dp_row [0:ROW_CELLS];
  int                    word_pos;

  verdict_t verdict_q[$];
  int       fail_count;
  int       reqs_sent;
  int       stuck_cycles;
  bit       src_gaps_on;
  bit       sink_gaps_on;
  bit       hold_req;
  int       hold_left;

  // Free-running clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int edit_budget();
    return (pat_edits > MAX_EDITS_LIMIT) ? int'(MAX_EDITS_LIMIT) : int'(pat_edits);
  endfunction

  function automatic int pattern_span();
    return (int'(pat_len) > ROW_CELLS) ? ROW_CELLS : int'(pat_len);
  endfunction

  function automatic logic [CHAR_W-1:0] pat_byte(input int j);
    return (j < 8) ? pat_lo[j*8 +: 8] : pat_hi[(j-8)*8 +: 8];
  endfunction

  function automatic int cap_at(input int v, input int cap);
    return (v > cap) ? cap : v;
  endfunction

  // Return the row to its start-of-word values under the current cap
  task automatic load_row_zero();
    int j;
    int cap;
    cap = edit_budget() + 1;
    for (j = 0; j <= ROW_CELLS; j++) dp_row[j] = DIST_W'(cap_at(j, cap));
  endtask

  // Advance the distance row by one accepted request and queue any verdict
  task automatic advance_row(input logic [CHAR_W-1:0] ch, input logic last,
                             input logic empty);
    int e;
    int cap;
    int n;
    int j;
    int ins;
    int del;
    int sub;
    int m;
    int word_dist;
    int prev [0:ROW_CELLS];
    verdict_t v;
    e   = edit_budget();
    cap = e + 1;
    n   = pattern_span();
    if (empty) begin
      word_dist = cap_at(n, cap);
      word_pos  = 0;
      load_row_zero();
      v.matched  = (word_dist <= e);
      v.distance = DIST_W'(word_dist);
      verdict_q.insert(verdict_q.size(), v);
      return;
    end
    for (j = 0; j <= ROW_CELLS; j++)
      prev[j] = cap_at((word_pos == 0) ? j : int'(dp_row[j]), cap);
    dp_row[0] = DIST_W'(cap_at(word_pos + 1, cap));
    for (j = 1; j <= n; j++) begin
      ins = int'(dp_row[j-1]) + 1;
      del = prev[j] + 1;
      sub = prev[j-1] + ((ch != pat_byte(j - 1)) ? 1 : 0);
      m   = (ins < del) ? ins : del;
      if (sub < m) m = sub;
      dp_row[j] = DIST_W'(cap_at(m, cap));
    end
    if (word_pos < SEEN_SAT) word_pos++;
    if (!last) return;
    word_dist = cap_at(int'(dp_row[n]), cap);
    word_pos  = 0;
    load_row_zero();
    v.matched  = (word_dist <= e);
    v.distance = DIST_W'(word_dist);
    verdict_q.insert(verdict_q.size(), v);
  endtask

  // Write all four registers back to back; only called while the row is idle
  task automatic load_config(input logic [LEN_REG_W-1:0] len, input logic [63:0] lo,
                             input logic [63:0] hi, input logic [EDITS_W-1:0] edits);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_PAT_LEN;
    cfg_data_i <= {{32'($urandom), 27'($urandom)}, len};
    @(posedge clk_i);
    cfg_idx_i  <= REG_PAT_LO;
    cfg_data_i <= lo;
    @(posedge clk_i);
    cfg_idx_i  <= REG_PAT_HI;
    cfg_data_i <= hi;
    @(posedge clk_i);
    cfg_idx_i  <= REG_MAX_EDITS;
    cfg_data_i <= {{32'($urandom), 29'($urandom)}, edits};
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    pat_len   = len;
    pat_lo    = lo;
    pat_hi    = hi;
    pat_edits = edits;
  endtask

  task automatic random_config();
    int r;
    logic [LEN_REG_W-1:0] len;
    r = $urandom_range(0, 9);
    if (r == 0) len = '0;
    else if (r == 1) len = LEN_REG_W'($urandom_range(ROW_CELLS + 1, 31));
    else len = LEN_REG_W'($urandom_range(1, ROW_CELLS));
    load_config(len, {$urandom, $urandom}, {$urandom, $urandom},
                EDITS_W'($urandom_range(0, 7)));
  endtask

  // Drop valid, wait for every verdict, then let the cell row drain
  task automatic settle_row();
    s_axis_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (ROW_SETTLE) @(posedge clk_i);
  endtask

  // Offer one request and hold it until accepted
  task automatic send_req(input logic [CHAR_W-1:0] ch, input logic last,
                          input logic empty);
    if (src_gaps_on && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    s_axis_tlast  <= last;
    s_axis_tuser  <= empty;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    advance_row(ch, last, empty);
    reqs_sent++;
  endtask

  // Send a word; with finish low the last character carries no tlast
  task automatic send_word(input word_t w, input logic finish);
    int i;
    if (w.size() == 0) begin
      if (finish) send_req(CHAR_W'($urandom), 1'($urandom), 1'b1);
      return;
    end
    for (i = 0; i < w.size(); i++)
      send_req(w[i], finish && (i == w.size() - 1), 1'b0);
  endtask

  // Pattern with a few random insertions, deletions and substitutions
  task automatic build_near_word(output word_t w);
    int j;
    int pos;
    w.delete();
    for (j = 0; j < pattern_span(); j++) w.insert(w.size(), pat_byte(j));
    repeat ($urandom_range(0, edit_budget() + 2)) begin
      pos = $urandom_range(0, w.size());
      case ($urandom_range(0, 2))
        0: begin
          if (pos < w.size()) w[pos] = CHAR_W'($urandom);
        end
        1: begin
          if (pos < w.size()) w.delete(pos);
        end
        default: begin
          w.insert(pos, CHAR_W'($urandom));
        end
      endcase
    end
  endtask

  // Short word mixing pattern bytes and random bytes
  task automatic build_noise_word(output word_t w);
    int j;
    w.delete();
    repeat ($urandom_range(1, 8)) begin
      j = $urandom_range(0, ROW_CELLS - 1);
      w.insert(w.size(), $urandom_range(0, 1) ? pat_byte(j) : CHAR_W'($urandom));
    end
  endtask

  // Mostly well-formed words, some noise, empty and abandoned words
  task automatic play_words(input int n_words);
    word_t w;
    int k;
    repeat (n_words) begin
      k = $urandom_range(0, 9);
      if (k <= 5) begin
        build_near_word(w);
        send_word(w, 1'b1);
      end else if (k <= 7) begin
        build_noise_word(w);
        send_word(w, 1'b1);
      end else if (k == 8) begin
        send_req(CHAR_W'($urandom), 1'($urandom), 1'b1);
      end else begin
        build_near_word(w);
        send_word(w, 1'b0);
        send_req(CHAR_W'($urandom), 1'($urandom), 1'b1);
      end
    end
  endtask

  // Reset configuration: empty pattern, one edit allowed
  task automatic test_reset_state();
    word_t w;
    send_req(8'hA5, 1'b1, 1'b1);
    w = '{8'h41};
    send_word(w, 1'b1);
    w = '{8'h78, 8'h79, 8'h7A};
    send_word(w, 1'b1);
  endtask

  // Byte extremes, oversized pattern length, max edits seven and zero
  task automatic test_pattern_extremes();
    word_t w;
    settle_row();
    load_config(5'd3, 64'h5AFF00, 64'h0, 3'd1);
    w = '{8'h00, 8'hFF, 8'h5A};
    send_word(w, 1'b1);
    w = '{8'hFF};
    send_word(w, 1'b1);
    w = '{8'hFF, 8'h00, 8'hA5, 8'h5A};
    send_word(w, 1'b1);
    send_req(8'hFF, 1'b1, 1'b1);
    settle_row();
    load_config(5'd31, {$urandom, $urandom}, {$urandom, $urandom}, 3'd7);
    send_req(8'h00, 1'b0, 1'b1);
    w = '{pat_byte(0), pat_byte(1)};
    send_word(w, 1'b1);
    settle_row();
    load_config(5'd16, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 3'd0);
    // word in progress dropped by an empty word
    w = '{8'hFF, 8'hFF};
    send_word(w, 1'b0);
    send_req(8'h00, 1'b1, 1'b1);
    w = '{8'hFF};
    send_word(w, 1'b1);
  endtask

  // Change the configuration between characters of one word
  task automatic test_midword_config();
    word_t w;
    settle_row();
    load_config(5'd4, 64'h64636261, 64'h0, 3'd2);
    w = '{8'h61, 8'h62};
    send_word(w, 1'b0);
    settle_row();
    load_config(5'd2, 64'h6261, 64'h0, 3'd0);
    w = '{8'h78};
    send_word(w, 1'b1);
  endtask

  // Random phases, each under its own configuration
  task automatic test_random_words();
    word_t w;
    int phase;
    phase = 0;
    while (reqs_sent < 240) begin
      settle_row();
      case (phase)
        0: load_config(5'd16, {$urandom, $urandom}, {$urandom, $urandom}, 3'd7);
        1: load_config(5'd0, {$urandom, $urandom}, {$urandom, $urandom}, 3'd0);
        2: load_config(5'd31, {$urandom, $urandom}, {$urandom, $urandom}, 3'd6);
        3: load_config(5'd1, {$urandom, $urandom}, {$urandom, $urandom}, 3'd0);
        default: random_config();
      endcase
      src_gaps_on  = (phase % 3 != 2);
      sink_gaps_on = (phase % 4 != 3);
      play_words($urandom_range(10, 20));
      // leave a word open across the next configuration change
      if ($urandom_range(0, 3) == 0) begin
        build_near_word(w);
        send_word(w, 1'b0);
      end
      phase++;
    end
  endtask

  // Words longer than the saturating character count
  task automatic test_long_words();
    word_t w;
    settle_row();
    src_gaps_on  = 1'b1;
    sink_gaps_on = 1'b1;
    load_config(5'd4, {$urandom, $urandom}, {$urandom, $urandom}, 3'd6);
    repeat (2) begin
      build_near_word(w);
      while (w.size() < 66 + $urandom_range(0, 8)) w.insert(0, CHAR_W'($urandom));
      send_word(w, 1'b1);
    end
  endtask

  // Stall the result side long enough to back up the cell row
  task automatic test_backpressure();
    word_t w;
    settle_row();
    src_gaps_on  = 1'b0;
    sink_gaps_on = 1'b0;
    load_config(5'd3, {$urandom, $urandom}, 64'h0, 3'd2);
    hold_req = 1'b1;
    repeat (30) begin
      build_near_word(w);
      send_word(w, 1'b1);
    end
  endtask

  // Closing stretch with no idling on either side
  task automatic test_steady_stream();
    settle_row();
    src_gaps_on  = 1'b0;
    sink_gaps_on = 1'b0;
    repeat (2) begin
      settle_row();
      random_config();
      play_words(10);
    end
  endtask

  // Result side ready: random stall bursts and one long hold on request
  initial begin
    m_axis_tready = 1'b0;
    hold_left     = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_left = LONG_HOLD;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (sink_gaps_on && $urandom_range(0, 5) == 0) begin
        hold_left = $urandom_range(1, 9) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Compare each accepted result with the oldest pending verdict
  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: result with none pending, actual tdata %h", $time, m_axis_tdata);
        fail_count++;
      end else begin
        want = verdict_q.pop_front();
        if (m_axis_tdata[0] !== want.matched) begin
          $display("%0t: matched expected %0b actual %0b", $time, want.matched,
                   m_axis_tdata[0]);
          fail_count++;
        end
        if (m_axis_tdata[3:1] !== want.distance) begin
          $display("%0t: distance expected %0d actual %0d", $time, want.distance,
                   m_axis_tdata[3:1]);
          fail_count++;
        end
        if (m_axis_tdata[7:4] !== 4'h0) begin
          $display("%0t: padding expected 0 actual %h", $time, m_axis_tdata[7:4]);
          fail_count++;
        end
      end
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // Test sequence
  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_PAT_LEN;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    s_axis_tuser  = 1'b0;
    fail_count    = 0;
    reqs_sent     = 0;
    hold_req      = 1'b0;
    src_gaps_on   = 1'b1;
    sink_gaps_on  = 1'b1;
    pat_len       = '0;
    pat_lo        = '0;
    pat_hi        = '0;
    pat_edits     = MAX_EDITS_RESET;
    word_pos      = 0;
    load_row_zero();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_pattern_extremes();
    test_midword_config();
    test_random_words();
    test_long_words();
    test_backpressure();
    test_steady_stream();

    settle_row();
    if (fail_count == 0 && verdict_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
